/* src/tccs_pkg.sv */
`timescale 1ns / 1ps
package tccs_pkg;

	// field widths
	localparam int ADDR_W  = 14;
	localparam int CON_W   = 3;
	localparam int CHAR_W  = 8;
	localparam int ATTR_W  = 8;
	localparam int MODE_W  = 2;

	// stream packing
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_USER_W = 2;

	localparam int IN_CON_LSB  = 0;
	localparam int IN_CHAR_LSB = IN_CON_LSB + CON_W;

	localparam int OUT_VADDR_LSB  = 0;
	localparam int OUT_VCHAR_LSB  = OUT_VADDR_LSB + ADDR_W;
	localparam int OUT_VATTR_LSB  = OUT_VCHAR_LSB + CHAR_W;
	localparam int OUT_CURSOR_LSB = OUT_VATTR_LSB + ATTR_W;
	localparam int OUT_START_LSB  = OUT_CURSOR_LSB + ADDR_W;
	localparam int OUT_CON_LSB    = OUT_START_LSB + ADDR_W;
	localparam int OUT_USED_W     = OUT_CON_LSB + CON_W;

	localparam int USER_VWRITE = 0;
	localparam int USER_CRTC   = 1;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic ATTR_IDX = 1'b0;   // register index bit paddr[2]
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

	// parameter defaults
	localparam int CONSOLES_DEF     = 3;
	localparam int ROW_WIDTH_DEF    = 80;
	localparam int SCREEN_CELLS_DEF = 2000;
	localparam int VMEM_WORDS_DEF   = 16384;

	// character codes
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

	// command queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE  = 2'd0,
		MODE_SELECT = 2'd1,
		MODE_UP     = 2'd2,
		MODE_DOWN   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_NEWLINE,
		CMD_BACKSPACE,
		CMD_PUTC,
		CMD_SELECT,
		CMD_UP,
		CMD_DOWN
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [CON_W-1:0]    con;
		logic [CHAR_W-1:0]   ch;
		logic [ADDR_W-1:0]   org;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} qflow_t;

endpackage

/* src/tccs_front.sv */
`timescale 1ns / 1ps
module tccs_front #(
	parameter int CONSOLES   = tccs_pkg::CONSOLES_DEF,
	parameter int VMEM_WORDS = tccs_pkg::VMEM_WORDS_DEF
) (
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [tccs_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [tccs_pkg::MODE_W-1:0]     s_tuser,
	output tccs_pkg::qflow_t                push,
	input  logic                            push_ready,
	output tccs_pkg::cmd_t                  cmd
);

	localparam int REGION = VMEM_WORDS / CONSOLES;

	logic [tccs_pkg::CON_W-1:0]  con;
	logic [tccs_pkg::CHAR_W-1:0] ch;
	logic                        con_ok;

	assign con = s_tdata[tccs_pkg::IN_CON_LSB +: tccs_pkg::CON_W];
	assign ch  = s_tdata[tccs_pkg::IN_CHAR_LSB +: tccs_pkg::CHAR_W];
	assign con_ok = {1'b0, con} < (tccs_pkg::CON_W + 1)'(CONSOLES);

	always_comb begin
		cmd.con = con;
		cmd.ch  = ch;
		cmd.org = tccs_pkg::ADDR_W'(con) * tccs_pkg::ADDR_W'(REGION);
		cmd.kind = tccs_pkg::CMD_NOP;
		if (con_ok) begin
			unique case (tccs_pkg::mode_t'(s_tuser))
				tccs_pkg::MODE_WRITE: begin
					if (ch == tccs_pkg::CH_NEWLINE)
						cmd.kind = tccs_pkg::CMD_NEWLINE;
					else if (ch == tccs_pkg::CH_BACKSPACE)
						cmd.kind = tccs_pkg::CMD_BACKSPACE;
					else
						cmd.kind = tccs_pkg::CMD_PUTC;
				end
				tccs_pkg::MODE_SELECT: cmd.kind = tccs_pkg::CMD_SELECT;
				tccs_pkg::MODE_UP:     cmd.kind = tccs_pkg::CMD_UP;
				tccs_pkg::MODE_DOWN:   cmd.kind = tccs_pkg::CMD_DOWN;
				default:               cmd.kind = tccs_pkg::CMD_NOP;
			endcase
		end
	end

	assign s_tready   = push_ready;
	assign push.valid = s_tvalid & push_ready;
	assign push.ready = push_ready;

endmodule

/* src/tccs_queue.sv */
`timescale 1ns / 1ps
module tccs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  tccs_pkg::qflow_t push,
	output logic             push_ready,
	input  tccs_pkg::cmd_t   push_cmd,
	output logic             pop_valid,
	input  logic             pop_ready,
	output tccs_pkg::cmd_t   pop_cmd
);

	tccs_pkg::cmd_t                  mem_q [tccs_pkg::QUEUE_DEPTH];
	logic [tccs_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [tccs_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [tccs_pkg::QCNT_W-1:0]     cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = cnt_q != tccs_pkg::QCNT_W'(tccs_pkg::QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push.valid & push.ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	// depth is a power of two, pointers wrap on their own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* src/tccs_back.sv */
`timescale 1ns / 1ps
module tccs_back #(
	parameter int CONSOLES     = tccs_pkg::CONSOLES_DEF,
	parameter int ROW_WIDTH    = tccs_pkg::ROW_WIDTH_DEF,
	parameter int SCREEN_CELLS = tccs_pkg::SCREEN_CELLS_DEF,
	parameter int VMEM_WORDS   = tccs_pkg::VMEM_WORDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	output logic                             q_ready,
	input  tccs_pkg::cmd_t                   q_cmd,
	input  logic [tccs_pkg::ATTR_W-1:0]      attr,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tccs_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic [tccs_pkg::OUT_USER_W-1:0]  m_tuser
);

	localparam int REGION   = VMEM_WORDS / CONSOLES;
	localparam int ROWW     = $clog2(REGION / ROW_WIDTH + 3);
	localparam int COLW     = $clog2(ROW_WIDTH);
	localparam int CIW      = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;
	localparam int SC_ROWS  = SCREEN_CELLS / ROW_WIDTH;
	localparam int SC_R     = SCREEN_CELLS % ROW_WIDTH;
	localparam int QW       = $clog2(SC_ROWS + 1);
	localparam int CW       = ((ROWW > QW) ? ROWW : QW) + 1;
	localparam int LAST_REL = REGION - 2;
	localparam int LQ       = LAST_REL / ROW_WIDTH;
	localparam int LR       = LAST_REL % ROW_WIDTH;
	localparam bit NL_EN    = REGION > ROW_WIDTH;
	localparam int NL_REL   = NL_EN ? (REGION - ROW_WIDTH - 1) : 0;
	localparam int NQ       = NL_REL / ROW_WIDTH;
	localparam int NR       = NL_REL % ROW_WIDTH;
	localparam int SPAN     = REGION - SCREEN_CELLS;
	localparam int SDQ      = (SPAN > 0) ? ((SPAN + ROW_WIDTH - 1) / ROW_WIDTH) : 0;
	localparam int AW1      = tccs_pkg::ADDR_W + 1;

	// per-console position as (row, column) relative to the region origin
	logic [COLW-1:0] col_q  [CONSOLES];
	logic [ROWW-1:0] crow_q [CONSOLES];
	logic [ROWW-1:0] srow_q [CONSOLES];
	logic [tccs_pkg::CON_W-1:0] sel_q;

	logic [CIW-1:0]  idx;
	logic [COLW-1:0] col, nc, wcol;
	logic [ROWW-1:0] crow, srow, nr, ns, wrow;
	logic [CW-1:0]   fit_lhs, fit_rhs;
	logic            wr, upd, writes_cur, putc_ok, nl_ok;
	logic [tccs_pkg::CHAR_W-1:0] wch;
	logic [tccs_pkg::CON_W-1:0]  sel_d;
	logic            pop, s2_ready, s1_ready;

	// stage 1: position result in rows
	logic                         valid_s1, wr_s1, upd_s1;
	logic [tccs_pkg::ADDR_W-1:0]  org_s1;
	logic [ROWW-1:0]              wrow_s1, crow_s1, srow_s1;
	logic [COLW-1:0]              wcol_s1, ccol_s1;
	logic [tccs_pkg::CHAR_W-1:0]  ch_s1;
	logic [tccs_pkg::ATTR_W-1:0]  attr_s1;
	logic [tccs_pkg::CON_W-1:0]   sel_s1;

	// stage 2: output register
	logic                              valid_s2;
	logic [tccs_pkg::OUT_DATA_W-1:0]   data_s2;
	logic [tccs_pkg::OUT_USER_W-1:0]   user_s2;
	logic [tccs_pkg::OUT_DATA_W-1:0]   data_d;
	logic [tccs_pkg::OUT_USER_W-1:0]   user_d;

	logic [AW1-1:0] vaddr_w, cur_w, start_w;

	assign idx = q_cmd.con[CIW-1:0];

	always_comb begin
		col  = col_q[idx];
		crow = crow_q[idx];
		srow = srow_q[idx];
		nc   = col;
		nr   = crow;
		ns   = srow;
		wr   = 1'b0;
		wrow = crow;
		wcol = col;
		wch  = q_cmd.ch;
		sel_d = sel_q;
		writes_cur = 1'b0;
		putc_ok = (crow < ROWW'(LQ)) || (crow == ROWW'(LQ) && col <= COLW'(LR));
		nl_ok   = NL_EN && ((crow < ROWW'(NQ)) || (crow == ROWW'(NQ) && col <= COLW'(NR)));
		unique case (q_cmd.kind)
			tccs_pkg::CMD_NEWLINE: begin
				writes_cur = 1'b1;
				if (nl_ok) begin
					nr = crow + 1'b1;
					nc = '0;
				end
			end
			tccs_pkg::CMD_BACKSPACE: begin
				writes_cur = 1'b1;
				if (crow != '0 || col != '0) begin
					if (col == '0) begin
						nr = crow - 1'b1;
						nc = COLW'(ROW_WIDTH - 1);
					end else begin
						nc = col - 1'b1;
					end
					wr   = 1'b1;
					wrow = nr;
					wcol = nc;
					wch  = tccs_pkg::CH_SPACE;
				end
			end
			tccs_pkg::CMD_PUTC: begin
				writes_cur = 1'b1;
				if (putc_ok) begin
					wr = 1'b1;
					if (col == COLW'(ROW_WIDTH - 1)) begin
						nr = crow + 1'b1;
						nc = '0;
					end else begin
						nc = col + 1'b1;
					end
				end
			end
			tccs_pkg::CMD_SELECT: sel_d = q_cmd.con;
			tccs_pkg::CMD_UP: begin
				if (srow != '0)
					ns = srow - 1'b1;
			end
			tccs_pkg::CMD_DOWN: begin
				if (srow < ROWW'(SDQ))
					ns = srow + 1'b1;
			end
			tccs_pkg::CMD_NOP: ;
			default: ;
		endcase
		// view must end past the new cursor: lowest start row is
		// nr - SC_ROWS + (nc >= SC_R), taken only if it moves the view down
		fit_lhs = CW'(nr) + CW'(nc >= COLW'(SC_R));
		fit_rhs = CW'(srow) + CW'(SC_ROWS);
		if (writes_cur && fit_lhs > fit_rhs)
			ns = ROWW'(fit_lhs - CW'(SC_ROWS));
	end

	assign upd      = q_cmd.kind != tccs_pkg::CMD_NOP;
	assign s2_ready = !valid_s2 || m_tready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign q_ready  = s1_ready;
	assign pop      = q_valid && s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CONSOLES; i++) begin
				col_q[i]  <= '0;
				crow_q[i] <= '0;
				srow_q[i] <= '0;
			end
			sel_q <= '0;
		end else if (pop) begin
			if (upd) begin
				col_q[idx]  <= nc;
				crow_q[idx] <= nr;
				srow_q[idx] <= ns;
			end
			sel_q <= sel_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s1_ready)
			valid_s1 <= q_valid;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			wr_s1   <= wr;
			upd_s1  <= upd;
			org_s1  <= q_cmd.org;
			wrow_s1 <= wrow;
			wcol_s1 <= wcol;
			crow_s1 <= nr;
			ccol_s1 <= nc;
			srow_s1 <= ns;
			ch_s1   <= wch;
			attr_s1 <= attr;
			sel_s1  <= sel_d;
		end
	end

	assign vaddr_w = AW1'(org_s1) + AW1'(ROW_WIDTH) * AW1'(wrow_s1) + AW1'(wcol_s1);
	assign cur_w   = AW1'(org_s1) + AW1'(ROW_WIDTH) * AW1'(crow_s1) + AW1'(ccol_s1);
	assign start_w = AW1'(org_s1) + AW1'(ROW_WIDTH) * AW1'(srow_s1);

	always_comb begin
		data_d = '0;
		data_d[tccs_pkg::OUT_CON_LSB +: tccs_pkg::CON_W] = sel_s1;
		if (wr_s1) begin
			data_d[tccs_pkg::OUT_VADDR_LSB +: tccs_pkg::ADDR_W] =
				vaddr_w[tccs_pkg::ADDR_W-1:0];
			data_d[tccs_pkg::OUT_VCHAR_LSB +: tccs_pkg::CHAR_W] = ch_s1;
			data_d[tccs_pkg::OUT_VATTR_LSB +: tccs_pkg::ATTR_W] = attr_s1;
		end
		if (upd_s1) begin
			data_d[tccs_pkg::OUT_CURSOR_LSB +: tccs_pkg::ADDR_W] =
				cur_w[tccs_pkg::ADDR_W-1:0];
			data_d[tccs_pkg::OUT_START_LSB +: tccs_pkg::ADDR_W] =
				start_w[tccs_pkg::ADDR_W-1:0];
		end
		user_d = '0;
		user_d[tccs_pkg::USER_VWRITE] = wr_s1;
		user_d[tccs_pkg::USER_CRTC]   = upd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (s2_ready)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s2_ready) begin
			data_s2 <= data_d;
			user_s2 <= user_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tuser  = user_s2;

endmodule

/* src/text_console_cursor_scroll.sv */
`timescale 1ns / 1ps
// Cursor and scroll controller for CONSOLES text consoles sharing one video memory,
// each console owning VMEM_WORDS/CONSOLES words. Takes one command per clock unless
// m_tready stalls the output, and returns one result per command in order, via the
// command queue, the stage-1 register and the stage-2 output register. The two-entry
// queue sits between the decode front and the execution back, so the slave side
// keeps taking commands while a result waits on m_tready, until the queue fills.
// Per console the cursor is a row/column pair and the view a start row, updated by
// a read-modify-write per command that sets the rate; the next stage forms word
// addresses from them. The character attribute is written at APB bytes 0 to 3.
module text_console_cursor_scroll #(
	parameter int CONSOLES     = tccs_pkg::CONSOLES_DEF,
	parameter int ROW_WIDTH    = tccs_pkg::ROW_WIDTH_DEF,
	parameter int SCREEN_CELLS = tccs_pkg::SCREEN_CELLS_DEF,
	parameter int VMEM_WORDS   = tccs_pkg::VMEM_WORDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tccs_pkg::PADDR_W-1:0]     paddr,
	input  logic [tccs_pkg::PDATA_W-1:0]     pwdata,
	output logic [tccs_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [2:0] console_index, [10:3] character
	input  logic [tccs_pkg::IN_DATA_W-1:0]   s_tdata,
	// [1:0] mode
	input  logic [tccs_pkg::MODE_W-1:0]      s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [13:0] vmem_address, [21:14] vmem_char, [29:22] vmem_attr,
	// [43:30] crtc_cursor, [57:44] crtc_start, [60:58] current_console
	output logic [tccs_pkg::OUT_DATA_W-1:0]  m_tdata,
	// [0] vmem_write, [1] crtc_update
	output logic [tccs_pkg::OUT_USER_W-1:0]  m_tuser
);

	logic [tccs_pkg::ATTR_W-1:0] attr_q;
	tccs_pkg::qflow_t            push;
	tccs_pkg::cmd_t              push_cmd;
	tccs_pkg::cmd_t              pop_cmd;
	logic                        push_ready;
	logic                        pop_valid;
	logic                        pop_ready;
	logic                        attr_sel;

	assign pready   = 1'b1;
	assign attr_sel = paddr[2] == tccs_pkg::ATTR_IDX;
	assign prdata   = attr_sel ? tccs_pkg::PDATA_W'(attr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			attr_q <= tccs_pkg::ATTR_RESET;
		else if (psel && penable && pwrite && pready && attr_sel)
			attr_q <= pwdata[tccs_pkg::ATTR_W-1:0];
	end

	tccs_front #(
		.CONSOLES   (CONSOLES),
		.VMEM_WORDS (VMEM_WORDS)
	) u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push       (push),
		.push_ready (push_ready),
		.cmd        (push_cmd)
	);

	tccs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	tccs_back #(
		.CONSOLES     (CONSOLES),
		.ROW_WIDTH    (ROW_WIDTH),
		.SCREEN_CELLS (SCREEN_CELLS),
		.VMEM_WORDS   (VMEM_WORDS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (pop_valid),
		.q_ready  (pop_ready),
		.q_cmd    (pop_cmd),
		.attr     (attr_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

/* src/tccs_checker.sv */
`timescale 1ns / 1ps
module tccs_checker #(
	parameter int CONSOLES = tccs_pkg::CONSOLES_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [tccs_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic [tccs_pkg::OUT_USER_W-1:0]  m_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a cell write only comes from a character command, which also updates the controller
	a_write_upd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[tccs_pkg::USER_VWRITE] |-> m_tuser[tccs_pkg::USER_CRTC])
		else $error("cell write without controller update");

	a_vmem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[tccs_pkg::USER_VWRITE] |->
			m_tdata[tccs_pkg::OUT_CURSOR_LSB-1:0] == '0)
		else $error("write fields not cleared");

	a_crtc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[tccs_pkg::USER_CRTC] |->
			m_tdata[tccs_pkg::OUT_CON_LSB-1:tccs_pkg::OUT_CURSOR_LSB] == '0)
		else $error("controller fields not cleared");

	a_con_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> {1'b0, m_tdata[tccs_pkg::OUT_CON_LSB +: tccs_pkg::CON_W]} <
			(tccs_pkg::CON_W + 1)'(CONSOLES))
		else $error("selected console out of range");

endmodule

bind text_console_cursor_scroll tccs_checker #(
	.CONSOLES (CONSOLES)
) u_tccs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
